/* hdl/flsa_pkg.sv */
package flsa_pkg;

   localparam int SLOT_W      = 12;
   localparam int COUNT_W     = SLOT_W + 1;
   localparam int TDATA_W     = ((SLOT_W + 7) / 8) * 8;
   localparam int SLOT_SPACE  = 1 << SLOT_W;
   localparam int BLOCK_SLOTS = 512;
   localparam int CHUNKS      = 8;
   localparam int RAW_POOL    = BLOCK_SLOTS * CHUNKS;
   localparam int POOL_INT    = (RAW_POOL > SLOT_SPACE) ? SLOT_SPACE : RAW_POOL;
   localparam logic [COUNT_W-1:0] POOL_SLOTS = COUNT_W'(POOL_INT);

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_EXHAUSTED = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_POP
   } flsa_state_type;

   typedef struct packed {
      logic [SLOT_W-1:0] granted_slot;
      logic              status;
   } flsa_result_type;

endpackage

/* hdl/flsa_out_buf.sv */
module flsa_out_buf
   import flsa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  flsa_result_type push_data,
   output logic            full,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output flsa_result_type rsp_data
);

   logic            main_valid_ff;
   logic            main_valid_in;
   flsa_result_type main_data_ff;
   flsa_result_type main_data_in;
   logic            skid_valid_ff;
   logic            skid_valid_in;
   flsa_result_type skid_data_ff;
   flsa_result_type skid_data_in;
   logic            main_free;

   assign main_free  = !main_valid_ff || rsp_tready;
   assign full       = skid_valid_ff;
   assign rsp_tvalid = main_valid_ff;
   assign rsp_data   = main_data_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            // promote the held beat, park the new one behind it
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = push_data;
         end else begin
            main_valid_in = push;
            main_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

/* hdl/free_list_slot_allocator_unit.sv */
// A result is registered in the output buffer when its request beat is accepted.
// A release or fresh allocation is ready for the next request unless the output
// buffer is full; a pop holds req_tready low in ST_POP for the link memory read.
// Reset: synchronous; empties the free list and the fresh counter, no clearing
// pass: link entries are only read after a release has written them.
module free_list_slot_allocator_unit
   import flsa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,   // [11:0] slot
   input  logic               req_tuser,   // [0] op
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,   // [11:0] granted_slot
   output logic               rsp_tuser    // [0] status
);

   flsa_state_type     state_ff;
   flsa_state_type     state_in;
   logic               head_valid_ff;
   logic               head_valid_in;
   logic [SLOT_W-1:0]  head_slot_ff;
   logic [SLOT_W-1:0]  head_slot_in;
   logic [COUNT_W-1:0] fresh_count_ff;
   logic [COUNT_W-1:0] fresh_count_in;

   logic [COUNT_W-1:0] link_mem [SLOT_SPACE];
   logic [COUNT_W-1:0] rd_data_ff;
   logic               mem_we;
   logic               mem_re;
   logic [SLOT_W-1:0]  mem_addr;
   logic [COUNT_W-1:0] mem_wdata;

   logic               accept;
   logic [SLOT_W-1:0]  req_slot;
   logic               buf_full;
   logic               push;
   flsa_result_type    push_data;
   flsa_result_type    rsp_data;

   assign req_slot   = req_tdata[SLOT_W-1:0];
   assign req_tready = (state_ff == ST_IDLE) && !buf_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in       = state_ff;
      head_valid_in  = head_valid_ff;
      head_slot_in   = head_slot_ff;
      fresh_count_in = fresh_count_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_addr       = req_slot;
      mem_wdata      = {head_valid_ff, head_slot_ff};
      push           = 1'b0;
      push_data      = '{granted_slot: '0, status: STATUS_OK};
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               push = 1'b1;
               if (req_tuser == OP_RELEASE) begin
                  push_data.granted_slot = req_slot;
                  if ({1'b0, req_slot} < POOL_SLOTS) begin
                     // link the slot in front of the head
                     mem_we        = 1'b1;
                     head_valid_in = 1'b1;
                     head_slot_in  = req_slot;
                  end
               end else if (head_valid_ff) begin
                  mem_re                 = 1'b1;
                  mem_addr               = head_slot_ff;
                  push_data.granted_slot = head_slot_ff;
                  state_in               = ST_POP;
               end else if (fresh_count_ff < POOL_SLOTS) begin
                  push_data.granted_slot = fresh_count_ff[SLOT_W-1:0];
                  fresh_count_in         = fresh_count_ff + COUNT_W'(1);
               end else begin
                  push_data.status = STATUS_EXHAUSTED;
               end
            end
         end
         ST_POP: begin
            head_valid_in = rd_data_ff[SLOT_W];
            head_slot_in  = rd_data_ff[SLOT_W-1:0];
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         head_valid_ff  <= 1'b0;
         fresh_count_ff <= '0;
      end else begin
         state_ff       <= state_in;
         head_valid_ff  <= head_valid_in;
         fresh_count_ff <= fresh_count_in;
      end
      head_slot_ff <= head_slot_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= link_mem[mem_addr];
      end
   end

   flsa_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (buf_full),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = TDATA_W'(rsp_data.granted_slot);
   assign rsp_tuser = rsp_data.status;

endmodule
